>>> rtl/xtea_pkg.sv
package xtea_pkg;

    localparam int WORD_W = 32;
    localparam int KEY_WORDS = 4;
    localparam int KEY_IDX_W = $clog2(KEY_WORDS);
    localparam int HI_KEY_SHIFT = 11;
    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] block_first;
        logic [WORD_W-1:0] block_second;
    } req_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_first;
        logic [WORD_W-1:0] out_second;
    } rsp_beat_t;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
    } stage_t;

    function automatic logic [WORD_W-1:0] mix_word(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] sum_key
    );
        mix_word = (((x << 4) ^ (x >> 5)) + x) ^ sum_key;
    endfunction

endpackage

>>> rtl/xtea_block_cipher.sv
// XTEA block cipher engine, encrypting or decrypting one 64-bit block per beat.
// The request channel (req_valid, req_stall, req) carries a mode bit (0 encrypt,
// 1 decrypt) and the block as two 32-bit words; the response channel (rsp_valid,
// rsp_stall, rsp) returns the processed pair in the same order.
// The 128-bit key is loaded through cfg_we, cfg_index and cfg_data, one 32-bit word
// per write. It must be loaded only while no beats are in flight; not enforced.
// Each half round is one pipeline stage, so a beat accepted at one clock edge is
// registered by every half-round stage in order before it is presented on rsp,
// where it is taken while rsp_stall is low. The depth of each stage is set by the
// two dependent 32-bit adds in a half round.
// A new beat is accepted every cycle while the response side does not stall.
// When a valid response is stalled, the whole pipeline holds and req_stall is
// raised; nothing is dropped or repeated.
// Reset clears all stage valid bits and sets every key word to zero.
module xtea_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  xtea_pkg::req_beat_t   req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output xtea_pkg::rsp_beat_t   rsp
);
    import xtea_pkg::*;

    localparam int STAGES = 2 * ROUNDS;

    key_t   key_reg;
    key_t   key_next;
    logic   advance;
    logic   stage_valid [0:STAGES];
    stage_t stage_data [0:STAGES];

    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            key_next[cfg_index[KEY_IDX_W-1:0]] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign advance = !(stage_valid[STAGES] && rsp_stall);
    assign req_stall = !advance;

    assign stage_valid[0] = req_valid;
    assign stage_data[0].mode = req.mode;
    assign stage_data[0].y = req.block_first;
    assign stage_data[0].z = req.block_second;

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        xtea_half_round #(
            .ROUNDS   (ROUNDS),
            .HALF_IDX (g)
        ) u_half (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .key       (key_reg),
            .in_valid  (stage_valid[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    assign rsp_valid = stage_valid[STAGES];
    assign rsp.out_first = stage_data[STAGES].y;
    assign rsp.out_second = stage_data[STAGES].z;

endmodule

>>> rtl/xtea_half_round.sv
module xtea_half_round #(
    parameter int ROUNDS = 32,
    parameter int HALF_IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  xtea_pkg::key_t  key,
    input  logic            in_valid,
    input  xtea_pkg::stage_t in_data,
    output logic            out_valid,
    output xtea_pkg::stage_t out_data
);
    import xtea_pkg::*;

    localparam bit IS_EVEN = (HALF_IDX % 2) == 0;
    localparam int RND = HALF_IDX / 2;
    localparam int ENC_MULT = IS_EVEN ? RND : RND + 1;
    localparam int DEC_MULT = IS_EVEN ? ROUNDS - RND : ROUNDS - RND - 1;
    localparam logic [2*WORD_W-1:0] ENC_PROD = 64'(ENC_MULT) * {32'd0, DELTA};
    localparam logic [2*WORD_W-1:0] DEC_PROD = 64'(DEC_MULT) * {32'd0, DELTA};
    localparam logic [WORD_W-1:0] SUM_ENC = ENC_PROD[WORD_W-1:0];
    localparam logic [WORD_W-1:0] SUM_DEC = DEC_PROD[WORD_W-1:0];
    localparam logic [KEY_IDX_W-1:0] ENC_KIDX = IS_EVEN ? SUM_ENC[KEY_IDX_W-1:0]
        : SUM_ENC[HI_KEY_SHIFT +: KEY_IDX_W];
    localparam logic [KEY_IDX_W-1:0] DEC_KIDX = IS_EVEN
        ? SUM_DEC[HI_KEY_SHIFT +: KEY_IDX_W] : SUM_DEC[KEY_IDX_W-1:0];

    logic              valid_reg;
    logic              valid_next;
    stage_t            data_reg;
    stage_t            data_next;
    logic              upd_y;
    logic [WORD_W-1:0] x_word;
    logic [WORD_W-1:0] tgt_word;
    logic [WORD_W-1:0] sum_key;
    logic [WORD_W-1:0] f_word;
    logic [WORD_W-1:0] new_word;

    always_comb
    begin
        upd_y = IS_EVEN ^ in_data.mode;
        x_word = upd_y ? in_data.z : in_data.y;
        tgt_word = upd_y ? in_data.y : in_data.z;
        sum_key = in_data.mode ? (SUM_DEC + key[DEC_KIDX]) : (SUM_ENC + key[ENC_KIDX]);
        f_word = mix_word(x_word, sum_key);
        new_word = in_data.mode ? (tgt_word - f_word) : (tgt_word + f_word);
        data_next = in_data;
        if (upd_y)
        begin
            data_next.y = new_word;
        end
        else
        begin
            data_next.z = new_word;
        end
        valid_next = advance ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

    a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> valid_reg == $past(in_valid))
        else $error("stage valid did not follow its input");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid_reg))
        else $error("stage valid changed while held");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !advance && valid_reg |=> $stable(data_reg))
        else $error("held stage data changed");

endmodule
